/* sv/fmswd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fmswd_pkg;

    // Store geometry
    localparam int SLOTS_PER_BANK = 12;
    localparam int FM_BANKS       = 4;
    localparam int REGS_PER_SLOT  = 16;
    localparam int SLOT_STORE     = SLOTS_PER_BANK * FM_BANKS * REGS_PER_SLOT;
    localparam int ADDR_W         = $clog2(SLOT_STORE);
    localparam int SLOT_W         = $clog2(SLOTS_PER_BANK);
    localparam int BANK_W         = $clog2(FM_BANKS);
    localparam int ROW_W          = $clog2(SLOTS_PER_BANK * FM_BANKS);
    localparam int REG_W          = $clog2(REGS_PER_SLOT);

    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(SLOT_STORE - 1);

    // Port codes
    localparam logic [2:0] PORT_FM0   = 3'd0;
    localparam logic [2:0] PORT_FM1   = 3'd1;
    localparam logic [2:0] PORT_NOTE  = 3'd4;
    localparam logic [2:0] PORT_GROUP = 3'd6;

    // Address fields
    localparam logic [1:0] SLOT_NONE  = 2'd3;
    localparam logic [3:0] NOTE_REG   = 4'd9;
    localparam logic [3:0] GROUP_REG  = 4'd0;
    localparam logic [5:0] TIMER_HI   = 6'b000100;  // 0x10..0x13

    // Sync modes
    localparam logic [1:0] SYNC_FOUR  = 2'd0;
    localparam logic [1:0] SYNC_PAIR  = 2'd1;
    localparam logic [1:0] SYNC_THREE = 2'd2;

    // Reset values
    localparam logic [7:0] DATA_RST = 8'hFF;
    localparam logic [1:0] SYNC_RST = 2'd3;

    // Controller -> datapath commands
    typedef struct packed {
        logic clr;       // clearing pass write
        logic load;      // latch request
        logic exec;      // decode, small stores, copy mask
        logic rd;        // slot store read
        logic wr;        // slot store compare and write
        logic out_load;  // result into output register
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic clear_done;
        logic fm_op;
        logic mask_last;
    } t_status;

    // Slot registers that follow the group sync mode
    function automatic logic is_synced(input logic [3:0] r);
        return (r == 4'd0) || (r == 4'd9) || (r == 4'd10) ||
               (r == 4'd12) || (r == 4'd13) || (r == 4'd14);
    endfunction

endpackage

`default_nettype wire

/* sv/fm_slot_write_dedup_filter.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_ready      i_port, i_reg_addr, i_write_data
// output    out        o_out_valid / i_out_ready    o_keep
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_data (force_first_mode)
//
// A request that touches no FM slot copy passes through the idle, execute and
// output states; otherwise each of its one to four copies adds a read state and a
// compare/write state on the single slot store memory.
// After reset a clearing pass writes all 768 slot store entries; o_in_ready is
// low during it, config writes are taken as ever.
// The output register holds a result while the next request is accepted; a
// request finishing while the output is still full waits until it is taken.

module fm_slot_write_dedup_filter (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire [2:0]  i_port,
    input  wire [7:0]  i_reg_addr,
    input  wire [7:0]  i_write_data,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic       o_keep,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire        i_cfg_data
);

    fmswd_pkg::t_cmd    cmd;
    fmswd_pkg::t_status sts;

    // Config register is always writable
    assign o_cfg_ready = 1'b1;

    fmswd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    fmswd_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_port       (i_port),
        .i_reg_addr   (i_reg_addr),
        .i_write_data (i_write_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_keep       (o_keep)
    );

endmodule

`default_nettype wire

/* sv/fmswd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module fmswd_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output fmswd_pkg::t_cmd   o_cmd,
    input  wire fmswd_pkg::t_status i_sts
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_EXEC  = 6'b000100,
        ST_RD    = 6'b001000,
        ST_WR    = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.fm_op ? ST_RD : ST_OUT;
            end
            ST_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_WR;
            end
            ST_WR: begin
                o_cmd.wr = 1'b1;
                n_state  = i_sts.mask_last ? ST_OUT : ST_RD;
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Output valid: set on load, cleared when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // Checks
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_EXEC))
        else $error("accepted request did not enter execute");

    a_wr_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR) |=> (r_state == ST_RD || r_state == ST_OUT))
        else $error("bad state after slot write");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_out_valid && !i_out_ready) |=>
        (r_state == ST_OUT && r_out_valid))
        else $error("result overwrote a pending output");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_out_valid)
        else $error("output load did not raise valid");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (!o_in_ready && !r_out_valid))
        else $error("request taken during clearing pass");

endmodule

`default_nettype wire

/* sv/fmswd_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module fmswd_dpath (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire fmswd_pkg::t_cmd i_cmd,
    output fmswd_pkg::t_status  o_sts,
    input  wire [2:0]           i_port,
    input  wire [7:0]           i_reg_addr,
    input  wire [7:0]           i_write_data,
    input  wire                 i_cfg_valid,
    input  wire                 i_cfg_data,
    output logic                o_keep
);

    // Latched request
    logic [2:0] r_port;
    logic [7:0] r_addr;
    logic [7:0] r_data;

    logic r_force;
    logic r_keep;
    logic [fmswd_pkg::FM_BANKS-1:0] r_mask;
    logic [fmswd_pkg::ADDR_W-1:0]   r_clr_cnt;
    logic [8:0]                     r_rd_word;

    // Small stores
    logic [7:0] r_group_data  [fmswd_pkg::SLOTS_PER_BANK];
    logic       r_group_first [fmswd_pkg::SLOTS_PER_BANK];
    logic [1:0] r_group_sync  [fmswd_pkg::SLOTS_PER_BANK];
    logic [7:0] r_note_data   [fmswd_pkg::SLOTS_PER_BANK];
    logic       r_note_first  [fmswd_pkg::SLOTS_PER_BANK];

    // Slot store: {first, data}
    logic [8:0] mem [fmswd_pkg::SLOT_STORE];

    logic [fmswd_pkg::SLOT_W-1:0] slot;
    logic                         slot_valid;
    logic [3:0]                   slot_reg;
    logic [1:0]                   mode;
    logic [fmswd_pkg::FM_BANKS-1:0] n_mask;
    logic [fmswd_pkg::FM_BANKS-1:0] own_mask;
    logic [fmswd_pkg::FM_BANKS-1:0] sel_hot;
    logic [fmswd_pkg::BANK_W-1:0]   bank;
    logic [fmswd_pkg::ROW_W-1:0]    row;
    logic [fmswd_pkg::ADDR_W-1:0]   maddr;
    logic                           slot_redundant;
    logic                           note_redundant;
    logic                           group_redundant;
    logic                           mem_we;
    logic [fmswd_pkg::ADDR_W-1:0]   mem_waddr;
    logic [8:0]                     mem_wdata;

    // Address decode: slot = block * 3 + position
    assign slot_valid = (r_addr[1:0] != fmswd_pkg::SLOT_NONE);
    assign slot       = {1'b0, r_addr[3:2], 1'b0} + {2'b00, r_addr[3:2]} +
                        {2'b00, r_addr[1:0]};
    assign slot_reg   = r_addr[7:4];
    assign mode       = slot_valid ? r_group_sync[slot] : fmswd_pkg::SYNC_RST;

    // Copy mask for FM writes
    assign own_mask = fmswd_pkg::FM_BANKS'(1) << r_port[1:0];
    always_comb begin
        n_mask = own_mask;
        if (fmswd_pkg::is_synced(slot_reg)) begin
            if (mode == fmswd_pkg::SYNC_FOUR && r_port == fmswd_pkg::PORT_FM0) begin
                n_mask = 4'b1111;
            end else if (mode == fmswd_pkg::SYNC_PAIR && r_port == fmswd_pkg::PORT_FM0) begin
                n_mask = 4'b0101;
            end else if (mode == fmswd_pkg::SYNC_PAIR && r_port == fmswd_pkg::PORT_FM1) begin
                n_mask = 4'b1010;
            end else if (mode == fmswd_pkg::SYNC_THREE && r_port == fmswd_pkg::PORT_FM0) begin
                n_mask = 4'b0111;
            end
        end
    end

    // Lowest pending bank
    assign sel_hot = r_mask & (~r_mask + fmswd_pkg::FM_BANKS'(1));
    always_comb begin
        if (r_mask[0]) begin
            bank = 2'd0;
        end else if (r_mask[1]) begin
            bank = 2'd1;
        end else if (r_mask[2]) begin
            bank = 2'd2;
        end else begin
            bank = 2'd3;
        end
    end

    // Store index = (bank * 12 + slot) * 16 + reg
    assign row   = {1'b0, bank, 3'b000} + {2'b00, bank, 2'b00} + {2'b00, slot};
    assign maddr = {row, slot_reg};

    // Compare against stored copies
    assign slot_redundant  = !r_rd_word[8] && (r_rd_word[7:0] == r_data);
    assign note_redundant  = !r_note_first[slot] && (r_note_data[slot] == r_data);
    assign group_redundant = !r_group_first[slot] && (r_group_data[slot] == r_data);

    // Status
    assign o_sts.clear_done = (r_clr_cnt == fmswd_pkg::CLR_LAST);
    assign o_sts.fm_op      = !r_port[2] && slot_valid;
    assign o_sts.mask_last  = ((r_mask & ~sel_hot) == '0);

    // Request latch, output register and config
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_port <= i_port;
            r_addr <= i_reg_addr;
            r_data <= i_write_data;
        end
        if (i_cmd.out_load) begin
            o_keep <= r_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_force <= 1'b0;
        end else if (i_cfg_valid) begin
            r_force <= i_cfg_data;
        end
    end

    // Clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr && !o_sts.clear_done) begin
            r_clr_cnt <= r_clr_cnt + fmswd_pkg::ADDR_W'(1);
        end
    end

    // Result flag and copy mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= 1'b0;
            r_mask <= '0;
        end else if (i_cmd.exec) begin
            r_mask <= '0;
            if (!r_port[2]) begin
                r_keep <= !slot_valid;
                if (slot_valid) begin
                    r_mask <= n_mask;
                end
            end else if (r_port == fmswd_pkg::PORT_NOTE) begin
                r_keep <= !(slot_valid && slot_reg == fmswd_pkg::NOTE_REG &&
                            note_redundant);
            end else if (r_port == fmswd_pkg::PORT_GROUP) begin
                if (r_addr[7:4] != fmswd_pkg::GROUP_REG) begin
                    r_keep <= (r_addr[7:2] != fmswd_pkg::TIMER_HI);
                end else begin
                    r_keep <= !(slot_valid && group_redundant);
                end
            end else begin
                r_keep <= 1'b1;
            end
        end else if (i_cmd.wr) begin
            r_mask <= r_mask & ~sel_hot;
            if (!slot_redundant) begin
                r_keep <= 1'b1;
            end
        end
    end

    // Note and group stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fmswd_pkg::SLOTS_PER_BANK; i++) begin
                r_group_data[i]  <= fmswd_pkg::DATA_RST;
                r_group_first[i] <= 1'b1;
                r_group_sync[i]  <= fmswd_pkg::SYNC_RST;
                r_note_data[i]   <= fmswd_pkg::DATA_RST;
                r_note_first[i]  <= 1'b1;
            end
        end else if (i_cmd.exec && slot_valid) begin
            if (r_port == fmswd_pkg::PORT_NOTE && slot_reg == fmswd_pkg::NOTE_REG &&
                !note_redundant) begin
                r_note_data[slot]  <= r_data;
                r_note_first[slot] <= r_force;
            end
            if (r_port == fmswd_pkg::PORT_GROUP && r_addr[7:4] == fmswd_pkg::GROUP_REG &&
                !group_redundant) begin
                r_group_data[slot]  <= r_data;
                r_group_first[slot] <= r_force;
                r_group_sync[slot]  <= r_data[1:0];
            end
        end
    end

    // Slot store write port: clearing pass or changed copy
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = maddr;
        mem_wdata = {r_force, r_data};
        if (i_cmd.clr) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_cnt;
            mem_wdata = {1'b1, fmswd_pkg::DATA_RST};
        end else if (i_cmd.wr && !slot_redundant) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd) begin
            r_rd_word <= mem[maddr];
        end
    end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    // Port codes not in the package
    localparam logic [2:0] PORT_FM2   = 3'd2;
    localparam logic [2:0] PORT_FM3   = 3'd3;
    localparam logic [2:0] PORT_SPARE = 3'd5;
    localparam logic [2:0] PORT_LAST  = 3'd7;

    // Group port address ranges
    localparam logic [7:0] TIMER_FIRST = 8'h10;
    localparam logic [7:0] TIMER_LAST  = 8'h13;

    // Slot registers that follow the group sync mode
    localparam logic [3:0] SYNCED_REG [6] = '{4'd0, 4'd9, 4'd10, 4'd12, 4'd13, 4'd14};

    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 24;

    typedef struct packed {
        logic [2:0] port;
        logic [7:0] addr;
        logic [7:0] data;
    } t_fm_req;

    // DUT connections
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       in_valid    = 1'b0;
    logic [2:0] in_port     = '0;
    logic [7:0] in_addr     = '0;
    logic [7:0] in_data     = '0;
    logic       out_ready   = 1'b0;
    logic       cfg_valid   = 1'b0;
    logic       cfg_data    = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_keep;
    logic       o_cfg_ready;

    // Shadow copy of the block's stores
    logic [7:0] sh_slot_data  [fmswd_pkg::SLOT_STORE];
    bit         sh_slot_first [fmswd_pkg::SLOT_STORE];
    logic [7:0] sh_grp_data   [fmswd_pkg::SLOTS_PER_BANK];
    bit         sh_grp_first  [fmswd_pkg::SLOTS_PER_BANK];
    logic [1:0] sh_grp_sync   [fmswd_pkg::SLOTS_PER_BANK];
    logic [7:0] sh_note_data  [fmswd_pkg::SLOTS_PER_BANK];
    bit         sh_note_first [fmswd_pkg::SLOTS_PER_BANK];
    bit         force_first = 1'b0;

    t_fm_req write_backlog [$];
    bit      keep_due [$];
    int      fails         = 0;
    int      send_idle_pct = 32;
    int      recv_idle_pct = 32;
    bit      stall_arm     = 1'b0;
    int      hold_count    = 0;
    t_fm_req next_req;
    bit      want_keep;

    fm_slot_write_dedup_filter u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_port       (in_port),
        .i_reg_addr   (in_addr),
        .i_write_data (in_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_keep       (o_keep),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (cfg_data)
    );

    // Clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Compare-and-store on one shadow slot copy; 1 when the write changes it
    function automatic bit slot_commit(int unsigned bank, int unsigned slot,
                                       logic [3:0] r, logic [7:0] v);
        int unsigned idx;
        idx = (bank * fmswd_pkg::SLOTS_PER_BANK + slot) * fmswd_pkg::REGS_PER_SLOT + r;
        if (!sh_slot_first[idx] && sh_slot_data[idx] == v)
            return 1'b0;
        sh_slot_first[idx] = force_first;
        sh_slot_data[idx]  = v;
        return 1'b1;
    endfunction

    // Expected keep flag for one register write, updating the shadow stores
    function automatic bit keep_of_write(logic [2:0] port, logic [7:0] a, logic [7:0] v);
        int unsigned slot;
        logic [3:0]  r;
        logic [3:0]  banks;
        bit          syn;
        bit          k;
        slot = a[3:2] * 3 + a[1:0];
        r    = a[7:4];
        k    = 1'b1;
        if (port < fmswd_pkg::FM_BANKS) begin
            if (a[1:0] != fmswd_pkg::SLOT_NONE) begin
                syn = 1'b0;
                foreach (SYNCED_REG[i])
                    if (r == SYNCED_REG[i]) syn = 1'b1;
                banks = 4'b0001 << port;
                if (syn && port == fmswd_pkg::PORT_FM0 &&
                    sh_grp_sync[slot] == fmswd_pkg::SYNC_FOUR)
                    banks = 4'b1111;
                else if (syn && port == fmswd_pkg::PORT_FM0 &&
                         sh_grp_sync[slot] == fmswd_pkg::SYNC_PAIR)
                    banks = 4'b0101;
                else if (syn && port == fmswd_pkg::PORT_FM1 &&
                         sh_grp_sync[slot] == fmswd_pkg::SYNC_PAIR)
                    banks = 4'b1010;
                else if (syn && port == fmswd_pkg::PORT_FM0 &&
                         sh_grp_sync[slot] == fmswd_pkg::SYNC_THREE)
                    banks = 4'b0111;
                k = 1'b0;
                for (int b = 0; b < fmswd_pkg::FM_BANKS; b++)
                    if (banks[b] && slot_commit(b, slot, r, v)) k = 1'b1;
            end
        end else if (port == fmswd_pkg::PORT_NOTE) begin
            if (a[1:0] != fmswd_pkg::SLOT_NONE && r == fmswd_pkg::NOTE_REG) begin
                if (!sh_note_first[slot] && sh_note_data[slot] == v) begin
                    k = 1'b0;
                end else begin
                    sh_note_first[slot] = force_first;
                    sh_note_data[slot]  = v;
                end
            end
        end else if (port == fmswd_pkg::PORT_GROUP) begin
            if (r != fmswd_pkg::GROUP_REG) begin
                k = !(a >= TIMER_FIRST && a <= TIMER_LAST);
            end else if (a[1:0] != fmswd_pkg::SLOT_NONE) begin
                if (!sh_grp_first[slot] && sh_grp_data[slot] == v) begin
                    k = 1'b0;
                end else begin
                    sh_grp_first[slot] = force_first;
                    sh_grp_data[slot]  = v;
                    sh_grp_sync[slot]  = v[1:0];
                end
            end
        end
        return k;
    endfunction

    function automatic t_fm_req fm_req(logic [2:0] p, logic [7:0] a, logic [7:0] d);
        t_fm_req w;
        w.port = p;
        w.addr = a;
        w.data = d;
        return w;
    endfunction

    // Random write, biased toward a few slots, synced registers and few data values
    function automatic t_fm_req random_write();
        t_fm_req     w;
        int unsigned pick;
        logic [3:0]  low;
        pick = $urandom_range(99);
        low  = ($urandom_range(1) == 0) ? 4'($urandom_range(2)) : 4'($urandom_range(15));
        case ($urandom_range(3))
            0:       w.data = 8'h00;
            1:       w.data = 8'hFF;
            2:       w.data = 8'($urandom_range(3));
            default: w.data = 8'($urandom);
        endcase
        if (pick < 45) begin
            w.port = ($urandom_range(1) == 0) ? fmswd_pkg::PORT_FM0 : 3'($urandom_range(3));
            w.addr = {($urandom_range(2) != 0) ? SYNCED_REG[$urandom_range(5)]
                                               : 4'($urandom_range(15)), low};
        end else if (pick < 72) begin
            w.port = fmswd_pkg::PORT_GROUP;
            if ($urandom_range(9) < 7)
                w.addr = {fmswd_pkg::GROUP_REG, low};
            else if ($urandom_range(1) == 0)
                w.addr = 8'($urandom_range(TIMER_LAST, TIMER_FIRST));
            else
                w.addr = 8'($urandom);
        end else if (pick < 84) begin
            w.port = fmswd_pkg::PORT_NOTE;
            w.addr = {($urandom_range(3) != 0) ? fmswd_pkg::NOTE_REG
                                               : 4'($urandom_range(15)), low};
        end else if (pick < 88) begin
            w.port = ($urandom_range(1) == 0) ? PORT_SPARE : PORT_LAST;
            w.addr = 8'($urandom);
        end else begin
            w.port = 3'($urandom);
            w.addr = 8'($urandom);
            w.data = 8'($urandom);
        end
        return w;
    endfunction

    // Sender: takes requests from the backlog, predicts on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready)
                keep_due.push_back(keep_of_write(in_port, in_addr, in_data));
            if (!in_valid || o_in_ready) begin
                if (write_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = write_backlog.pop_front();
                    in_valid <= 1'b1;
                    in_port  <= next_req.port;
                    in_addr  <= next_req.addr;
                    in_data  <= next_req.data;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready, with one long hold-off once armed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (stall_arm && hold_count < HOLD_CYCLES) begin
            out_ready <= 1'b0;
            hold_count++;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (keep_due.size() == 0) begin
                $display("%0t: result with nothing expected, keep=%0b", $time, o_keep);
                fails++;
            end else begin
                want_keep = keep_due.pop_front();
                if (o_keep !== want_keep) begin
                    $display("%0t: keep mismatch, expected %0b actual %0b",
                             $time, want_keep, o_keep);
                    fails++;
                end
            end
        end
    end

    task automatic write_mode(input bit m);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid   <= 1'b0;
        force_first = m;
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (write_backlog.size() != 0 || in_valid || keep_due.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic queue_random(input int n);
        t_fm_req w;
        t_fm_req prev;
        @(negedge i_clk);
        for (int i = 0; i < n; i++) begin
            // exact repeats exercise the redundant path
            if (i != 0 && $urandom_range(4) == 0)
                w = prev;
            else
                w = random_write();
            write_backlog.push_back(w);
            prev = w;
        end
    endtask

    // Stimulus sequence
    initial begin
        for (int i = 0; i < fmswd_pkg::SLOT_STORE; i++) begin
            sh_slot_data[i]  = fmswd_pkg::DATA_RST;
            sh_slot_first[i] = 1'b1;
        end
        for (int i = 0; i < fmswd_pkg::SLOTS_PER_BANK; i++) begin
            sh_grp_data[i]   = fmswd_pkg::DATA_RST;
            sh_grp_first[i]  = 1'b1;
            sh_grp_sync[i]   = fmswd_pkg::SYNC_RST;
            sh_note_data[i]  = fmswd_pkg::DATA_RST;
            sh_note_first[i] = 1'b1;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: no-slot field, repeats, each sync mode, note/group/timer ranges
        write_mode(1'b0);
        @(negedge i_clk);
        write_backlog.push_back(fm_req(fmswd_pkg::PORT_FM0, 8'h03, 8'h00));
        write_backlog.push_back(fm_req(fmswd_pkg::PORT_FM0, 8'h00, 8'h00));
        write_backlog.push_back(fm_req(fmswd_pkg::PORT_FM0, 8'h00, 8'h00));
        write_backlog.push_back(fm_req(fmswd_pkg::PORT_GROUP, 8'h00, 8'h00));
        write_backlog.push_back(fm_req(fmswd_pkg::PORT_GROUP, 8'h00, 8'h00));
        write_backlog.push_back(fm_req(fmswd_pkg::PORT_FM0, 8'h00, 8'h12));
        write_backlog.push_back(fm_req(PORT_FM3, 8'h00, 8'h12));
        write_backlog.push_back(fm_req(fmswd_pkg::PORT_GROUP, 8'h01, 8'h01));
        write_backlog.push_back(fm_req(fmswd_pkg::PORT_FM1, 8'h91, 8'h34));
        write_backlog.push_back(fm_req(PORT_FM3, 8'h91, 8'h34));
        write_backlog.push_back(fm_req(fmswd_pkg::PORT_GROUP, 8'h02, 8'h02));
        write_backlog.push_back(fm_req(fmswd_pkg::PORT_FM0, 8'hE2, 8'h56));
        write_backlog.push_back(fm_req(PORT_FM2, 8'hE2, 8'h56));
        write_backlog.push_back(fm_req(PORT_FM3, 8'hE2, 8'h56));
        write_backlog.push_back(fm_req(fmswd_pkg::PORT_NOTE, 8'h00, 8'h11));
        write_backlog.push_back(fm_req(fmswd_pkg::PORT_NOTE, 8'h95, 8'h07));
        write_backlog.push_back(fm_req(fmswd_pkg::PORT_NOTE, 8'h95, 8'h07));
        write_backlog.push_back(fm_req(fmswd_pkg::PORT_NOTE, 8'h97, 8'h07));
        write_backlog.push_back(fm_req(fmswd_pkg::PORT_NOTE, 8'hA0, 8'h00));
        write_backlog.push_back(fm_req(fmswd_pkg::PORT_NOTE, 8'hFF, 8'hFF));
        write_backlog.push_back(fm_req(fmswd_pkg::PORT_GROUP, TIMER_FIRST, 8'hAA));
        write_backlog.push_back(fm_req(fmswd_pkg::PORT_GROUP, TIMER_LAST, 8'h55));
        write_backlog.push_back(fm_req(fmswd_pkg::PORT_GROUP, 8'h14, 8'h01));
        write_backlog.push_back(fm_req(fmswd_pkg::PORT_GROUP, 8'hFF, 8'hFF));
        write_backlog.push_back(fm_req(fmswd_pkg::PORT_GROUP, 8'h0F, 8'h00));
        write_backlog.push_back(fm_req(PORT_SPARE, 8'h00, 8'h00));
        write_backlog.push_back(fm_req(PORT_LAST, 8'hFF, 8'hFF));
        write_backlog.push_back(fm_req(PORT_FM2, 8'hFE, 8'hFF));
        write_backlog.push_back(fm_req(PORT_FM2, 8'hFE, 8'hFF));
        drain();

        // Sticky first flags, back-to-back traffic
        write_mode(1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(150);
        drain();

        write_mode(1'b0);
        send_idle_pct = 32;
        recv_idle_pct = 32;
        queue_random(200);
        drain();

        write_mode(1'b1);
        queue_random(100);
        drain();

        // Long receiver hold-off while the sender keeps offering
        write_mode(1'b0);
        @(negedge i_clk);
        stall_arm = 1'b1;
        queue_random(150);
        drain();

        if (fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* fm_slot_write_dedup_filter.f */
sv/fmswd_pkg.sv
sv/fmswd_ctrl.sv
sv/fmswd_dpath.sv
sv/fm_slot_write_dedup_filter.sv
tb/tb_top.sv
